// ===== src/addressed_text_command_decoder_top_macros.svh =====
// assertion macros shared by the checker
`ifndef ADDRESSED_TEXT_COMMAND_DECODER_TOP_MACROS_SVH
`define ADDRESSED_TEXT_COMMAND_DECODER_TOP_MACROS_SVH

// property checked only outside reset
`define ATCD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ATCD_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/atcd_pkg.sv =====
// types, codes and keyword matcher shared by the decoder modules
package atcd_pkg;

  // configuration register indexes
  localparam logic REG_ID_FIRST  = 1'b0;
  localparam logic REG_ID_SECOND = 1'b1;

  localparam logic [7:0] ID_FIRST_RESET  = 8'd82;
  localparam logic [7:0] ID_SECOND_RESET = 8'd50;

  // command kinds on the result channel
  localparam logic [1:0] KIND_SET_SPEED = 2'd0;
  localparam logic [1:0] KIND_STOP      = 2'd1;
  localparam logic [1:0] KIND_STATUS    = 2'd2;

  // keyword matcher positions
  localparam logic [3:0] KW_NONE   = 4'd0;
  localparam logic [3:0] KW_S      = 4'd1;
  localparam logic [3:0] KW_SP     = 4'd2;
  localparam logic [3:0] KW_SPD    = 4'd3;
  localparam logic [3:0] KW_NUMBER = 4'd4;
  localparam logic [3:0] KW_ST     = 4'd5;
  localparam logic [3:0] KW_STO    = 4'd6;
  localparam logic [3:0] KW_STOP   = 4'd7;
  localparam logic [3:0] KW_STA    = 4'd8;
  localparam logic [3:0] KW_STAT   = 4'd9;
  localparam logic [3:0] KW_STATU  = 4'd10;
  localparam logic [3:0] KW_STATUS = 4'd11;
  localparam logic [3:0] KW_DEAD   = 4'd15;

  // number parser phases
  localparam logic [1:0] NP_BLANK  = 2'd0;
  localparam logic [1:0] NP_SIGN   = 2'd1;
  localparam logic [1:0] NP_DIGITS = 2'd2;
  localparam logic [1:0] NP_DONE   = 2'd3;

  localparam logic [8:0] MAG_SAT   = 9'd256;
  localparam logic [8:0] MAG_MAX   = 9'd255;

  // one classified received byte
  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       nul;
    logic       blank;
    logic       is_digit;
    logic [3:0] digit;
    logic       plus;
    logic       minus;
  } token_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

  function automatic logic [3:0] keyword_next(input logic [3:0] k, input logic [7:0] b);
    logic [3:0] n;
    n = KW_DEAD;
    unique case (k)
      KW_NONE:  n = (b == "S") ? KW_S : KW_DEAD;
      KW_S:     n = (b == "P") ? KW_SP : ((b == "T") ? KW_ST : KW_DEAD);
      KW_SP:    n = (b == "D") ? KW_SPD : KW_DEAD;
      KW_SPD:   n = (b == ":") ? KW_NUMBER : KW_DEAD;
      KW_ST:    n = (b == "O") ? KW_STO : ((b == "A") ? KW_STA : KW_DEAD);
      KW_STO:   n = (b == "P") ? KW_STOP : KW_DEAD;
      KW_STA:   n = (b == "T") ? KW_STAT : KW_DEAD;
      KW_STAT:  n = (b == "U") ? KW_STATU : KW_DEAD;
      KW_STATU: n = (b == "S") ? KW_STATUS : KW_DEAD;
      default:  n = KW_DEAD;
    endcase
    return n;
  endfunction

endpackage

// ===== src/atcd_front.sv =====
// input side: takes received bytes and classifies them for the queue
module atcd_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  input  logic                 queue_full,
  output logic                 in_stall,
  output logic                 push,
  output atcd_pkg::token_t     push_tok
);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_tok.data     = in_rx_byte;
    push_tok.eol      = (in_rx_byte == 8'h0A) || (in_rx_byte == 8'h0D);
    push_tok.nul      = (in_rx_byte == 8'h00);
    push_tok.blank    = (in_rx_byte == " ") || (in_rx_byte == 8'h09) ||
                        (in_rx_byte == 8'h0B) || (in_rx_byte == 8'h0C);
    push_tok.is_digit = (in_rx_byte >= "0") && (in_rx_byte <= "9");
    push_tok.digit    = 4'(in_rx_byte - 8'h30);
    push_tok.plus     = (in_rx_byte == "+");
    push_tok.minus    = (in_rx_byte == "-");
  end

endmodule

// ===== src/atcd_queue.sv =====
// two-entry queue between the classifier and the line decoder
module atcd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  atcd_pkg::token_t      push_tok,
  input  logic                  pop,
  output logic                  full,
  output atcd_pkg::queue_head_t head
);

  atcd_pkg::token_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.tok   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== src/atcd_back.sv =====
// line decoder: address check, keyword matcher, number parser, result register
module atcd_back #(
  parameter int LINE_LIMIT = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  atcd_pkg::queue_head_t head,
  input  logic [7:0]            id_first,
  input  logic [7:0]            id_second,
  input  logic                  out_stall,
  output logic                  pop,
  output logic                  out_valid,
  output logic [1:0]            out_command_kind,
  output logic [7:0]            out_speed_value
);

  localparam int CNT_W = $clog2(LINE_LIMIT + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             addr_r, addr_nxt;
  logic [3:0]       kw_r, kw_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [8:0]       mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             ended_r, ended_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r;
  logic [7:0]       speed_r;

  logic             res_valid;
  logic [1:0]       res_kind;
  logic [7:0]       res_speed;
  logic [11:0]      mag_acc;
  atcd_pkg::token_t tok;

  assign tok              = head.tok;
  assign pop              = head.valid && (!out_valid_r || !out_stall);
  assign out_valid        = out_valid_r;
  assign out_command_kind = kind_r;
  assign out_speed_value  = speed_r;

  // magnitude times ten plus the new digit
  assign mag_acc = 12'({mag_r, 3'b000}) + 12'({mag_r, 1'b0}) + 12'(tok.digit);

  always_comb begin
    count_nxt = count_r;
    addr_nxt  = addr_r;
    kw_nxt    = kw_r;
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ended_nxt = ended_r;
    res_valid = 1'b0;
    res_kind  = atcd_pkg::KIND_SET_SPEED;
    res_speed = 8'd0;
    if (pop) begin
      if (tok.eol) begin
        if (count_r != '0) begin
          if (count_r >= CNT_W'(3) && addr_r) begin
            if (kw_r == atcd_pkg::KW_NUMBER) begin
              if (mag_r <= atcd_pkg::MAG_MAX && (!neg_r || mag_r == 9'd0)) begin
                res_valid = 1'b1;
                res_speed = mag_r[7:0];
              end
            end else if (kw_r == atcd_pkg::KW_STOP) begin
              res_valid = 1'b1;
              res_kind  = atcd_pkg::KIND_STOP;
            end else if (kw_r == atcd_pkg::KW_STATUS) begin
              res_valid = 1'b1;
              res_kind  = atcd_pkg::KIND_STATUS;
            end
          end
          count_nxt = '0;
          addr_nxt  = 1'b1;
          kw_nxt    = atcd_pkg::KW_NONE;
          phase_nxt = atcd_pkg::NP_BLANK;
          mag_nxt   = 9'd0;
          neg_nxt   = 1'b0;
          ended_nxt = 1'b0;
        end
      end else if (count_r < CNT_W'(LINE_LIMIT)) begin
        count_nxt = count_r + CNT_W'(1);
        if (!ended_r) begin
          if (tok.nul) begin
            // nul ends the text; inside the address it spoils the match
            ended_nxt = 1'b1;
            if (count_r < CNT_W'(3)) begin
              addr_nxt = 1'b0;
            end
          end else if (count_r == CNT_W'(0)) begin
            addr_nxt = addr_r && (tok.data == id_first);
          end else if (count_r == CNT_W'(1)) begin
            addr_nxt = addr_r && (tok.data == id_second);
          end else if (count_r == CNT_W'(2)) begin
            addr_nxt = addr_r && (tok.data == ":");
          end else if (kw_r == atcd_pkg::KW_NUMBER) begin
            unique case (phase_r)
              atcd_pkg::NP_BLANK: begin
                if (tok.blank) begin
                  phase_nxt = atcd_pkg::NP_BLANK;
                end else if (tok.plus) begin
                  phase_nxt = atcd_pkg::NP_SIGN;
                end else if (tok.minus) begin
                  neg_nxt   = 1'b1;
                  phase_nxt = atcd_pkg::NP_SIGN;
                end else if (tok.is_digit) begin
                  mag_nxt   = 9'(tok.digit);
                  phase_nxt = atcd_pkg::NP_DIGITS;
                end else begin
                  phase_nxt = atcd_pkg::NP_DONE;
                end
              end
              atcd_pkg::NP_SIGN: begin
                if (tok.is_digit) begin
                  mag_nxt   = 9'(tok.digit);
                  phase_nxt = atcd_pkg::NP_DIGITS;
                end else begin
                  phase_nxt = atcd_pkg::NP_DONE;
                end
              end
              atcd_pkg::NP_DIGITS: begin
                if (tok.is_digit) begin
                  mag_nxt = (mag_acc > 12'(atcd_pkg::MAG_SAT)) ? atcd_pkg::MAG_SAT
                                                               : mag_acc[8:0];
                end else begin
                  phase_nxt = atcd_pkg::NP_DONE;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end else begin
            kw_nxt = atcd_pkg::keyword_next(kw_r, tok.data);
          end
        end
      end
    end
    // result slot frees when taken, refills on the same edge
    out_valid_nxt = pop ? res_valid : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      addr_r      <= 1'b1;
      kw_r        <= atcd_pkg::KW_NONE;
      phase_r     <= atcd_pkg::NP_BLANK;
      mag_r       <= 9'd0;
      neg_r       <= 1'b0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      addr_r      <= addr_nxt;
      kw_r        <= kw_nxt;
      phase_r     <= phase_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind_r  <= res_kind;
      speed_r <= res_speed;
    end
  end

endmodule

// ===== src/addressed_text_command_decoder_top.sv =====
// top level of the addressed text command decoder
//
// Bytes of a text stream enter on in_valid/in_rx_byte; a transaction takes
// place at a rising edge with in_valid high and in_stall low. Lines end at
// CR or LF; only the first LINE_LIMIT bytes of a line count. A line reading
// <id1><id2>:SPD:<n>, :STOP or :STATUS yields one command on out_valid,
// out_command_kind and out_speed_value, taken when out_stall is low.
// The two address characters are written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Throughput: one byte per cycle while the result side does not stall, set by
// the line decoder, which updates its matcher state once per byte popped from
// the two-entry queue. With the queue empty, the line-ending byte is written into
// the queue, then popped by the line decoder, which loads its result register.
// While out_stall holds a command, the queue still takes up to two more
// bytes, then in_stall rises until the command is taken.
// Synchronous reset (rst_n low) empties the queue, drops any pending
// command, clears the line state and loads address "R2".
module addressed_text_command_decoder_top #(
  parameter int LINE_LIMIT = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_command_kind,
  output logic [7:0] out_speed_value,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic                  push;
  logic                  pop;
  logic                  queue_full;
  atcd_pkg::token_t      push_tok;
  atcd_pkg::queue_head_t head;
  logic [7:0]            id_first_r, id_first_nxt;
  logic [7:0]            id_second_r, id_second_nxt;

  always_comb begin
    id_first_nxt  = id_first_r;
    id_second_nxt = id_second_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        atcd_pkg::REG_ID_FIRST:  id_first_nxt  = cfg_data;
        atcd_pkg::REG_ID_SECOND: id_second_nxt = cfg_data;
        default: id_first_nxt = id_first_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_first_r  <= atcd_pkg::ID_FIRST_RESET;
      id_second_r <= atcd_pkg::ID_SECOND_RESET;
    end else begin
      id_first_r  <= id_first_nxt;
      id_second_r <= id_second_nxt;
    end
  end

  atcd_front u_front (
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_tok   (push_tok)
  );

  atcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .full     (queue_full),
    .head     (head)
  );

  atcd_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .id_first         (id_first_r),
    .id_second        (id_second_r),
    .out_stall        (out_stall),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_command_kind (out_command_kind),
    .out_speed_value  (out_speed_value)
  );

endmodule

// ===== src/atcd_checker.sv =====
// port-level checks on the decoder, bound to the top level
`include "addressed_text_command_decoder_top_macros.svh"

module atcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_command_kind,
  input logic [7:0] out_speed_value
);

  `ATCD_ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_command_kind) && $stable(out_speed_value), "stalled result changed")

  `ATCD_ASSERT_RUN(a_kind_legal, clk, rst_n, out_valid |-> out_command_kind <= atcd_pkg::KIND_STATUS, "illegal command kind")

  `ATCD_ASSERT_RUN(a_speed_zero, clk, rst_n, out_valid && out_command_kind != atcd_pkg::KIND_SET_SPEED |-> out_speed_value == 8'd0, "speed set on stop or status")

  `ATCD_ASSERT_ALL(a_reset_clears, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind addressed_text_command_decoder_top atcd_checker u_atcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_command_kind (out_command_kind),
  .out_speed_value  (out_speed_value)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the addressed text command decoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT = 31;
  localparam logic [7:0] CR  = 8'h0D;
  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] NUL = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] speed;
  } command_t;

  // line decoder model plus the queue of commands it predicts
  class command_scoreboard;
    logic [7:0] id_first = atcd_pkg::ID_FIRST_RESET;
    logic [7:0] id_second = atcd_pkg::ID_SECOND_RESET;
    int kept = 0;
    bit addr_ok = 1'b1;
    string word = "";
    bit number_mode = 1'b0;
    bit word_dead = 1'b0;
    bit text_done = 1'b0;
    bit negative = 1'b0;
    logic [1:0] num_phase = atcd_pkg::NP_BLANK;
    int magnitude = 0;
    command_t pending_cmds[$];
    int failures = 0;

    function void start_line();
      kept = 0;
      addr_ok = 1'b1;
      word = "";
      number_mode = 1'b0;
      word_dead = 1'b0;
      text_done = 1'b0;
      negative = 1'b0;
      num_phase = atcd_pkg::NP_BLANK;
      magnitude = 0;
    endfunction

    static function bit is_prefix(string w, string kw);
      return w.len() <= kw.len() && kw.substr(0, w.len() - 1) == w;
    endfunction

    // atoi-style parse, magnitude saturates at 256
    function void number_char(logic [7:0] b);
      bit digit;
      bit blank;
      digit = b >= "0" && b <= "9";
      blank = b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C;
      case (num_phase)
        atcd_pkg::NP_BLANK: begin
          if (b == "+") begin
            num_phase = atcd_pkg::NP_SIGN;
          end else if (b == "-") begin
            negative = 1'b1;
            num_phase = atcd_pkg::NP_SIGN;
          end else if (digit) begin
            magnitude = int'(b) - int'("0");
            num_phase = atcd_pkg::NP_DIGITS;
          end else if (!blank) begin
            num_phase = atcd_pkg::NP_DONE;
          end
        end
        atcd_pkg::NP_SIGN: begin
          if (digit) begin
            magnitude = int'(b) - int'("0");
            num_phase = atcd_pkg::NP_DIGITS;
          end else begin
            num_phase = atcd_pkg::NP_DONE;
          end
        end
        atcd_pkg::NP_DIGITS: begin
          if (digit) begin
            magnitude = magnitude * 10 + (int'(b) - int'("0"));
            if (magnitude > int'(atcd_pkg::MAG_SAT)) magnitude = int'(atcd_pkg::MAG_SAT);
          end else begin
            num_phase = atcd_pkg::NP_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int pos;
      if (b == LF || b == CR) begin
        if (kept > 0) begin
          if (kept >= 3 && addr_ok) begin
            if (number_mode) begin
              if (magnitude <= int'(atcd_pkg::MAG_MAX) && (!negative || magnitude == 0))
                pending_cmds.push_back(command_t'{atcd_pkg::KIND_SET_SPEED,
                                                  magnitude[7:0]});
            end else if (!word_dead && word == "STOP") begin
              pending_cmds.push_back(command_t'{atcd_pkg::KIND_STOP, 8'd0});
            end else if (!word_dead && word == "STATUS") begin
              pending_cmds.push_back(command_t'{atcd_pkg::KIND_STATUS, 8'd0});
            end
          end
          start_line();
        end
        return;
      end
      if (kept >= LINE_LIMIT) return;
      pos = kept;
      kept++;
      if (text_done) return;
      // a nul ends the text, and spoils the address if it falls inside it
      if (b == NUL) begin
        text_done = 1'b1;
        if (pos < 3) addr_ok = 1'b0;
        return;
      end
      case (pos)
        0: addr_ok = addr_ok && b == id_first;
        1: addr_ok = addr_ok && b == id_second;
        2: addr_ok = addr_ok && b == ":";
        default: begin
          if (number_mode) begin
            number_char(b);
          end else if (!word_dead) begin
            word = $sformatf("%s%c", word, b);
            if (word == "SPD:") number_mode = 1'b1;
            else if (!(is_prefix(word, "SPD:") || is_prefix(word, "STOP") ||
                       is_prefix(word, "STATUS")))
              word_dead = 1'b1;
          end
        end
      endcase
    endfunction

    function void check_command(logic [1:0] kind, logic [7:0] speed);
      command_t want;
      if (pending_cmds.size() == 0) begin
        $error("command with none expected: command_kind %0d speed_value %0d", kind, speed);
        failures++;
        return;
      end
      want = pending_cmds.pop_front();
      if (kind !== want.kind) begin
        $error("command_kind: expected %0d, actual %0d", want.kind, kind);
        failures++;
      end
      if (speed !== want.speed) begin
        $error("speed_value: expected %0d, actual %0d", want.speed, speed);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_command_kind;
  logic [7:0] out_speed_value;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = atcd_pkg::REG_ID_FIRST;
  logic [7:0] cfg_data = 8'd0;

  command_scoreboard cmd_sb = new();
  logic [7:0] line_bytes[$];
  int items_sent = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  string keywords[3] = '{"SPD:", "STOP", "STATUS"};

  addressed_text_command_decoder_top #(.LINE_LIMIT(LINE_LIMIT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_command_kind(out_command_kind),
    .out_speed_value(out_speed_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      cmd_sb.check_command(out_command_kind, out_speed_value);
  end

  // receiver back-pressure: random bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 10)) @(negedge clk);
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    cmd_sb.note_byte(b);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_line(input logic [7:0] term);
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    send_byte(term);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_bytes.delete();
    add_text(s);
    send_line(LF);
  endtask

  function automatic void add_address();
    line_bytes.push_back(cmd_sb.id_first);
    line_bytes.push_back(cmd_sb.id_second);
    line_bytes.push_back(":");
  endfunction

  function automatic void add_number();
    logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0B, 8'h0C};
    int sel;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) line_bytes.push_back(blanks[$urandom_range(0, 3)]);
    sel = $urandom_range(0, 5);
    if (sel == 0) line_bytes.push_back("+");
    else if (sel == 1) line_bytes.push_back("-");
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      add_text($sformatf("%0d", $urandom_range(0, 255)));
    end else if (sel == 7) begin
      add_text($sformatf("%0d", $urandom_range(256, 99999)));
    end else if (sel == 9) begin
      add_text("00");
      add_text($sformatf("%0d", $urandom_range(0, 40)));
    end
    if ($urandom_range(0, 3) == 0) line_bytes.push_back(8'($urandom_range(32, 126)));
  endfunction

  function automatic void add_command();
    int sel;
    int n;
    string kw;
    sel = $urandom_range(0, 9);
    if (sel <= 4) begin
      add_text("SPD:");
      add_number();
    end else if (sel <= 6) begin
      add_text("STOP");
    end else if (sel <= 8) begin
      add_text("STATUS");
    end else begin
      // truncated or mistyped keyword
      kw = keywords[$urandom_range(0, 2)];
      n = $urandom_range(0, kw.len() - 1);
      for (int i = 0; i < n; i++) line_bytes.push_back(kw[i]);
      line_bytes.push_back(8'($urandom_range(32, 126)));
    end
  endfunction

  task automatic send_random_line();
    int r;
    r = $urandom_range(0, 99);
    line_bytes.delete();
    if (r < 80) begin
      add_address();
      if (r >= 70) line_bytes[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
      add_command();
      if ($urandom_range(0, 9) == 0)
        line_bytes.insert($urandom_range(0, line_bytes.size()), 8'($urandom_range(0, 255)));
    end else if (r < 88) begin
      repeat ($urandom_range(1, 40)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 94) begin
      add_address();
      if ($urandom_range(0, 1) == 0) begin
        // number straddling the end of the kept text
        add_text("SPD:");
        repeat ($urandom_range(18, 26)) line_bytes.push_back(" ");
        add_text("123456");
      end else begin
        add_command();
        while (line_bytes.size() < $urandom_range(32, 45))
          line_bytes.push_back(8'($urandom_range(32, 126)));
      end
    end else begin
      add_address();
      add_command();
      line_bytes.insert($urandom_range(0, line_bytes.size()), NUL);
      repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_line($urandom_range(0, 1) ? LF : CR);
    if ($urandom_range(0, 4) == 0) send_byte($urandom_range(0, 1) ? LF : CR);
  endtask

  // wait for every predicted command, then let the input queue drain
  task automatic settle();
    while (cmd_sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_id(input logic idx, input logic [7:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == atcd_pkg::REG_ID_FIRST) cmd_sb.id_first = value;
    else cmd_sb.id_second = value;
  endtask

  function automatic logic [7:0] pick_id();
    logic [7:0] v;
    v = 8'($urandom_range(1, 255));
    if (v == CR || v == LF) v = "A";
    return v;
  endfunction

  initial begin
    logic [7:0] first_id;
    logic [7:0] second_id;
    int target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("R2:SPD:0");
    send_text("R2:SPD:255");
    send_text("R2:SPD:256");
    send_text("R2:SPD:99999");
    send_text("R2:SPD: \t-0");
    send_text("R2:SPD:-7");
    send_text("R2:SPD:");
    send_text("R2:SPD:+12x");
    send_text("R2:STOP");
    send_text("R2:STATUS");
    send_text("R2:STOPS");
    send_text("R1:STATUS");
    send_text("R2");
    line_bytes.delete();
    add_text("R2:SPD:");
    line_bytes.push_back(8'hFF);
    send_line(CR);
    send_byte(LF);
    line_bytes.delete();
    add_text("R");
    line_bytes.push_back(NUL);
    add_text(":STOP");
    send_line(LF);
    line_bytes.delete();
    add_text("R2:STATUS");
    line_bytes.push_back(NUL);
    add_text("xyz");
    send_line(CR);
    // digits past the line limit are dropped
    line_bytes.delete();
    add_text("R2:SPD:");
    repeat (24) line_bytes.push_back(" ");
    add_text("77");
    send_line(LF);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: {first_id, second_id} = {8'hFF, 8'hFF};
        1: {first_id, second_id} = {8'h00, 8'h01};
        3: {first_id, second_id} = {8'h01, 8'h7F};
        5: {first_id, second_id} = {8'h52, 8'h32};
        default: {first_id, second_id} = {pick_id(), pick_id()};
      endcase
      write_id(atcd_pkg::REG_ID_FIRST, first_id);
      write_id(atcd_pkg::REG_ID_SECOND, second_id);
      quiet = p == 5;
      if (p == 0) begin
        // hold the result side so the input side backs up
        long_hold = 1'b1;
        repeat (12) begin
          line_bytes.delete();
          add_address();
          add_text("STATUS");
          send_line(LF);
        end
        settle();
      end
      target = items_sent + (p == 1 ? 100 : 240);
      while (items_sent < target) begin
        send_random_line();
        if ($urandom_range(0, 60) == 0) settle();
      end
    end
    settle();

    if (cmd_sb.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
